// File: design/ws2812_strip_serializer_top_macros.svh
// Assertion macros for the WS2812 strip serializer checker.
// Used by ws2812_strip_serializer_chk.sv; depends on nothing else.
`ifndef WS2812_STRIP_SERIALIZER_TOP_MACROS_SVH
`define WS2812_STRIP_SERIALIZER_TOP_MACROS_SVH

// same-cycle implication
`define WSS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ws2812 serializer check failed");

// next-cycle implication
`define WSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ws2812 serializer check failed");

`endif

// File: design/wss_pkg.sv
// Shared types, constants and the brightness scaler for the WS2812 strip serializer.
// No dependencies.
`default_nettype none

package wss_pkg;

   localparam int LED_COUNT    = 3;
   localparam int LedPosW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int BitsPerLed   = 24;
   localparam int CsrAddrW     = 5;

   localparam logic [LedPosW-1:0] LastLed = LedPosW'(LED_COUNT - 1);
   localparam logic [4:0]         LastBit = 5'(BitsPerLed - 1);

   localparam logic [7:0]  RstColorRed    = 8'd255;
   localparam logic [7:0]  RstColorGreen  = 8'd79;
   localparam logic [7:0]  RstColorBlue   = 8'd0;
   localparam logic [7:0]  RstOneHigh     = 8'd31;
   localparam logic [7:0]  RstZeroHigh    = 8'd15;
   localparam logic [15:0] RstLatchTicks  = 16'd6400;

   typedef enum logic [2:0] {
      REG_COLOR_RED   = 3'd0,
      REG_COLOR_GREEN = 3'd1,
      REG_COLOR_BLUE  = 3'd2,
      REG_ONE_HIGH    = 3'd3,
      REG_ZERO_HIGH   = 3'd4,
      REG_LATCH       = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_BITS  = 3'b010,
      PH_LATCH = 3'b100
   } phase_type;

   typedef enum logic {
      ACT_TICK   = 1'b0,
      ACT_UPDATE = 1'b1
   } action_type;

   typedef struct packed {
      logic data_line;
      logic busy_res;
      logic update_accepted;
      logic frame_done;
   } rsp_type;

   // floor(c*b/255), exact for every product of two 8-bit levels
   function automatic logic [7:0] scale_level(input logic [7:0] c, input logic [7:0] b);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = c * b;
      sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

`default_nettype wire

// File: design/ws2812_strip_serializer_top.sv
// WS2812 strip serializer: configuration registers, frame sequencer, result buffer.
// Depends on wss_pkg.
//
// Usage: each req beat is either a tick (one step of bit timing) or an update
// request carrying a brightness. Every accepted beat yields exactly one rsp beat
// holding the data line level, busy flag, update-accepted flag and frame-done flag.
// An update is honored only while idle; it latches color*brightness/255 per channel
// and starts a frame of LED_COUNT x 24 bits, green-red-blue, MSB first, followed by
// the latch gap. Updates while busy yield a result but change nothing.
// Registered result; it shows the cycle after acceptance unless held in the skid.
// Throughput: one beat per cycle unless stalled; single registered sequencer step.
// A two-entry result buffer (output register plus skid) lets one more beat in while
// the receiver stalls; req_ready drops only once both entries hold results.
// Reset (synchronous, active high) returns the sequencer to idle, empties the
// buffer and restores register defaults. The CSR port is APB-style, 32-bit data,
// always ready; a write takes effect from the next req beat, also within a frame.
`default_nettype none

module ws2812_strip_serializer_top
   import wss_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_action,
   input  wire logic [7:0]          req_brightness,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_data_line,
   output logic                     rsp_busy_res,
   output logic                     rsp_update_accepted,
   output logic                     rsp_frame_done,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [7:0]  color_red_ff, color_green_ff, color_blue_ff;
   logic [7:0]  one_high_ff, zero_high_ff;
   logic [15:0] latch_ticks_ff;

   phase_type          phase_ff, phase_in;
   logic [23:0]        pixel_shift_ff, pixel_shift_in;
   logic [23:0]        scaled_color_ff, scaled_color_in;
   logic [4:0]         bit_pos_ff, bit_pos_in;
   logic [LedPosW-1:0] led_pos_ff, led_pos_in;
   logic [15:0]        tick_ff, tick_in;

   rsp_type result;
   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic          req_fire, rsp_fire, csr_write;
   reg_index_type csr_index;
   logic [15:0]   tick_inc;
   logic [7:0]    high_now, low_now, high_next;
   logic [8:0]    bit_total;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CsrAddrW-1:2]);

   always_comb begin
      unique case (csr_index)
         REG_COLOR_RED:   csr_prdata = {24'd0, color_red_ff};
         REG_COLOR_GREEN: csr_prdata = {24'd0, color_green_ff};
         REG_COLOR_BLUE:  csr_prdata = {24'd0, color_blue_ff};
         REG_ONE_HIGH:    csr_prdata = {24'd0, one_high_ff};
         REG_ZERO_HIGH:   csr_prdata = {24'd0, zero_high_ff};
         REG_LATCH:       csr_prdata = {16'd0, latch_ticks_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_red_ff   <= RstColorRed;
         color_green_ff <= RstColorGreen;
         color_blue_ff  <= RstColorBlue;
         one_high_ff    <= RstOneHigh;
         zero_high_ff   <= RstZeroHigh;
         latch_ticks_ff <= RstLatchTicks;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COLOR_RED:   color_red_ff   <= csr_pwdata[7:0];
            REG_COLOR_GREEN: color_green_ff <= csr_pwdata[7:0];
            REG_COLOR_BLUE:  color_blue_ff  <= csr_pwdata[7:0];
            REG_ONE_HIGH:    one_high_ff    <= csr_pwdata[7:0];
            REG_ZERO_HIGH:   zero_high_ff   <= csr_pwdata[7:0];
            REG_LATCH:       latch_ticks_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // sequencer step
   assign high_now  = pixel_shift_ff[23] ? one_high_ff : zero_high_ff;
   assign low_now   = pixel_shift_ff[23] ? zero_high_ff : one_high_ff;
   assign bit_total = {1'b0, high_now} + {1'b0, low_now};
   assign tick_inc  = tick_ff + 16'd1;

   always_comb begin
      phase_in        = phase_ff;
      pixel_shift_in  = pixel_shift_ff;
      scaled_color_in = scaled_color_ff;
      bit_pos_in      = bit_pos_ff;
      led_pos_in      = led_pos_ff;
      tick_in         = tick_ff;
      result          = '0;
      if (action_type'(req_action) == ACT_UPDATE) begin
         if (phase_ff == PH_IDLE) begin
            scaled_color_in = {scale_level(color_green_ff, req_brightness),
                               scale_level(color_red_ff, req_brightness),
                               scale_level(color_blue_ff, req_brightness)};
            pixel_shift_in  = scaled_color_in;
            bit_pos_in      = 5'd0;
            led_pos_in      = '0;
            tick_in         = 16'd0;
            phase_in        = PH_BITS;
            result.update_accepted = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: ;
            PH_BITS: begin
               tick_in = tick_inc;
               if (tick_inc >= {7'd0, bit_total}) begin
                  tick_in        = 16'd0;
                  pixel_shift_in = {pixel_shift_ff[22:0], 1'b0};
                  bit_pos_in     = bit_pos_ff + 5'd1;
                  if (bit_pos_ff == LastBit) begin
                     bit_pos_in     = 5'd0;
                     pixel_shift_in = scaled_color_ff;
                     led_pos_in     = led_pos_ff + 1'b1;
                     if (led_pos_ff == LastLed) begin
                        led_pos_in = '0;
                        phase_in   = PH_LATCH;
                     end
                  end
               end
            end
            PH_LATCH: begin
               tick_in = tick_inc;
               if (tick_inc >= latch_ticks_ff) begin
                  tick_in           = 16'd0;
                  phase_in          = PH_IDLE;
                  result.frame_done = 1'b1;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      high_next        = pixel_shift_in[23] ? one_high_ff : zero_high_ff;
      result.busy_res  = (phase_in != PH_IDLE);
      result.data_line = (phase_in == PH_BITS) && (tick_in < {8'd0, high_next});
   end

   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign req_ready = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         pixel_shift_ff  <= 24'd0;
         scaled_color_ff <= 24'd0;
         bit_pos_ff      <= 5'd0;
         led_pos_ff      <= '0;
         tick_ff         <= 16'd0;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         pixel_shift_ff  <= pixel_shift_in;
         scaled_color_ff <= scaled_color_in;
         bit_pos_ff      <= bit_pos_in;
         led_pos_ff      <= led_pos_in;
         tick_ff         <= tick_in;
      end
   end

   // two-entry result buffer
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_data_line       = out_ff.data_line;
   assign rsp_busy_res        = out_ff.busy_res;
   assign rsp_update_accepted = out_ff.update_accepted;
   assign rsp_frame_done      = out_ff.frame_done;

endmodule

`default_nettype wire

// File: design/ws2812_strip_serializer_chk.sv
// Port-level checker for the WS2812 strip serializer, bound to the top level.
// Depends on ws2812_strip_serializer_top_macros.svh and ws2812_strip_serializer_top.
`default_nettype none
`include "ws2812_strip_serializer_top_macros.svh"

module ws2812_strip_serializer_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_data_line,
   input wire logic rsp_busy_res,
   input wire logic rsp_update_accepted,
   input wire logic rsp_frame_done
);

   `WSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_data_line, rsp_busy_res, rsp_update_accepted, rsp_frame_done}))
   `WSS_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_frame_done, !rsp_busy_res && !rsp_update_accepted)
   `WSS_ASSERT_IMPLY(a_update_busy, clock, reset, rsp_valid && rsp_update_accepted, rsp_busy_res)
   `WSS_ASSERT_IMPLY(a_idle_low, clock, reset, rsp_valid && !rsp_busy_res, !rsp_data_line)

endmodule

bind ws2812_strip_serializer_top ws2812_strip_serializer_chk u_chk (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_data_line       (rsp_data_line),
   .rsp_busy_res        (rsp_busy_res),
   .rsp_update_accepted (rsp_update_accepted),
   .rsp_frame_done      (rsp_frame_done)
);

`default_nettype wire
